// File: rtl/core/wbss_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner package
// Shared sizes, register indexes and the per-cell compare setup type.
// ----------------------------------------------------------------------------
package wbss_pkg;

	localparam int MAX_PATTERN_BYTES = 16;
	localparam int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int POS_W             = $clog2(MAX_PATTERN_BYTES);
	localparam int ADDR_W            = 32;
	localparam int HIT_W             = 16;
	localparam int CFG_IDX_W         = 3;
	localparam int CFG_DATA_W        = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT_LOW    = 3'd0,
		REG_PAT_HIGH   = 3'd1,
		REG_MASK       = 3'd2,
		REG_LENGTH     = 3'd3,
		REG_BASE       = 3'd4,
		REG_HIT_LIMIT  = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic       care;
		logic [7:0] ref_byte;
	} cell_cfg_t;

endpackage

// File: rtl/core/wbss_cell.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner window cell
// Holds one byte of the window, passes it to the next cell on every accepted
// item and compares it against its signature byte.
// ----------------------------------------------------------------------------
module wbss_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift_en,
	input  logic                flush,
	input  logic [7:0]          byte_in,
	input  wbss_pkg::cell_cfg_t cell_cfg,
	output logic [7:0]          byte_out,
	output logic                hit
);
	import wbss_pkg::*;

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift_en) begin
			byte_q <= flush ? 8'd0 : byte_in;
		end
	end

	assign byte_out = byte_q;
	assign hit      = !cell_cfg.care || (byte_q == cell_cfg.ref_byte);

endmodule

// File: rtl/core/wildcard_byte_signature_scanner.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner
// Streams region bytes through a row of window cells and reports the start
// address of every window that matches the wildcard signature, up to the hit limit.
// ----------------------------------------------------------------------------
// Input items carry one region byte and a scan_start flag; an item is taken
// when in_valid is high and in_stall is low. Each result item carries the
// address where a matching signature begins. Configuration registers are
// written through cfg_valid/cfg_ready, which is always ready; the user must
// write them only while the block is idle, as the block does not enforce it.
// One byte is taken every cycle while in_stall is low. An item accepted at a
// clock edge shifts the window at that edge; the cells compare in the next
// cycle and a hit is loaded into the output register when the compare stage
// advances. Throughput is set by the cell row, which shifts once per
// accepted byte.
// When the receiver stalls, the pending result holds in the output register,
// the compare stage keeps its item and in_stall rises only when both are full.
// Reset clears the window, offset, fill and hit counts and all configuration
// registers except pattern_length, which resets to one.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [wbss_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [wbss_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [7:0]                              data_byte,
	input  logic                                    scan_start,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [wbss_pkg::ADDR_W-1:0]             match_address
);
	import wbss_pkg::*;

	logic [63:0]                    pat_low_q;
	logic [63:0]                    pat_high_q;
	logic [MAX_PATTERN_BYTES-1:0]   compare_mask_q;
	logic [4:0]                     pattern_length_q;
	logic [ADDR_W-1:0]              region_base_q;
	logic [HIT_W-1:0]               hit_limit_q;

	logic [ADDR_W-1:0]              offset_q;
	logic [LEN_W-1:0]               fill_q;
	logic [HIT_W-1:0]               hits_q;

	logic                           valid_s1;
	logic                           start_s1;
	logic [ADDR_W-1:0]              here_s1;

	logic                           out_valid_q;
	logic [ADDR_W-1:0]              match_address_q;

	logic                           in_accept;
	logic                           s1_adv;
	logic [ADDR_W-1:0]              here;
	logic [LEN_W-1:0]               len_c;
	logic [7:0]                     sig_byte [MAX_PATTERN_BYTES];
	cell_cfg_t                      cell_cfg [MAX_PATTERN_BYTES];
	logic [7:0]                     chain [MAX_PATTERN_BYTES+1];
	logic [MAX_PATTERN_BYTES-1:0]   cell_hit;
	logic                           match;
	logic [HIT_W-1:0]               hits_eff;
	logic                           report;
	logic [ADDR_W-1:0]              addr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q        <= '0;
			pat_high_q       <= '0;
			compare_mask_q   <= '0;
			pattern_length_q <= 5'd1;
			region_base_q    <= '0;
			hit_limit_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_PAT_LOW:   pat_low_q        <= cfg_data;
				REG_PAT_HIGH:  pat_high_q       <= cfg_data;
				REG_MASK:      compare_mask_q   <= cfg_data[MAX_PATTERN_BYTES-1:0];
				REG_LENGTH:    pattern_length_q <= cfg_data[4:0];
				REG_BASE:      region_base_q    <= cfg_data[ADDR_W-1:0];
				REG_HIT_LIMIT: hit_limit_q      <= cfg_data[HIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign len_c = (pattern_length_q > 5'(MAX_PATTERN_BYTES)) ?
		LEN_W'(MAX_PATTERN_BYTES) : LEN_W'(pattern_length_q);

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			sig_byte[k]     = pat_low_q[k*8 +: 8];
			sig_byte[k + 8] = pat_high_q[k*8 +: 8];
		end
	end

	always_comb begin
		logic [LEN_W-1:0] pos;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			pos                  = len_c - LEN_W'(i) - LEN_W'(1);
			cell_cfg[i].care     = (LEN_W'(i) < len_c) && compare_mask_q[pos[POS_W-1:0]];
			cell_cfg[i].ref_byte = sig_byte[pos[POS_W-1:0]];
		end
	end

	assign s1_adv    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_accept = in_valid && !in_stall;
	assign here      = scan_start ? '0 : offset_q;

	assign chain[0] = data_byte;

	for (genvar g = 0; g < MAX_PATTERN_BYTES; g++) begin : g_cell
		wbss_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (in_accept),
			.flush    (scan_start && (g != 0)),
			.byte_in  (chain[g]),
			.cell_cfg (cell_cfg[g]),
			.byte_out (chain[g+1]),
			.hit      (cell_hit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
			start_s1 <= 1'b0;
			here_s1  <= '0;
		end else if (in_accept) begin
			offset_q <= here + ADDR_W'(1);
			if (scan_start) begin
				fill_q <= LEN_W'(1);
			end else if (fill_q < LEN_W'(MAX_PATTERN_BYTES)) begin
				fill_q <= fill_q + LEN_W'(1);
			end
			valid_s1 <= 1'b1;
			start_s1 <= scan_start;
			here_s1  <= here;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	assign match    = (len_c != '0) && (fill_q >= len_c) && (&cell_hit);
	assign hits_eff = start_s1 ? '0 : hits_q;
	assign report   = match && ((hit_limit_q == '0) || (hits_eff < hit_limit_q));
	assign addr     = region_base_q + here_s1 - (ADDR_W'(len_c) - ADDR_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q <= '0;
		end else if (s1_adv) begin
			if (report && (hits_eff != {HIT_W{1'b1}})) begin
				hits_q <= hits_eff + HIT_W'(1);
			end else begin
				hits_q <= hits_eff;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= report;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && report) begin
			match_address_q <= addr;
		end
	end

	assign out_valid     = out_valid_q;
	assign match_address = match_address_q;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner testbench
// Streams region bytes into the scanner under changing signature, mask,
// length, base and hit-limit settings. A local model of the scan window
// predicts every match address. Each address that comes out is compared in
// order with the prediction. Both sides insert random gaps, and the output
// side holds off once for a long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wbss_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int DRAIN_CYCLES     = 6;
	localparam int QUIET_LIMIT      = 2000;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int TOTAL_BYTES      = 1120;
	localparam int MAX_REPORTS      = 40;

	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_B = 3'd7;

	typedef struct packed {
		logic [7:0] value;
		logic       first;
	} region_byte_t;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic [7:0]            data_byte  = '0;
	logic                  scan_start = 1'b0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [ADDR_W-1:0]     match_address;

	region_byte_t      byte_queue[$];
	logic [ADDR_W-1:0] expected_hits[$];

	logic [63:0]       sig_low   = '0;
	logic [63:0]       sig_high  = '0;
	logic [15:0]       care_mask = '0;
	logic [4:0]        sig_len   = 5'd1;
	logic [ADDR_W-1:0] base_addr = '0;
	logic [HIT_W-1:0]  hit_cap   = '0;

	logic [7:0]        win[MAX_PATTERN_BYTES];
	logic [ADDR_W-1:0] scan_pos  = '0;
	logic [HIT_W-1:0]  hit_count = '0;
	int                win_fill  = 0;

	bit                in_took        = 1'b0;
	bit                no_gaps        = 1'b0;
	bit                want_long_hold = 1'b0;
	bit                long_hold_done = 1'b0;
	bit                progress;
	int                hold_left      = 0;
	int                quiet_cycles   = 0;
	int                errors         = 0;
	int                hits_checked   = 0;
	int                bytes_sent     = 0;
	int                settings_used  = 0;
	region_byte_t      next_byte;
	logic [ADDR_W-1:0] want_addr;

	wildcard_byte_signature_scanner u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.scan_start    (scan_start),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.match_address (match_address)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		foreach (win[i]) win[i] = '0;
	end

	task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
			input logic [ADDR_W-1:0] want);
		if (errors < MAX_REPORTS) begin
			$display("MISMATCH at %0t: %s (got %h, want %h)", $realtime, what, got, want);
		end
		errors++;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic start);
		logic [ADDR_W-1:0] here;
		logic [ADDR_W-1:0] back;
		logic [127:0]      sig;
		int                len;
		int                i;
		bit                hit;
		here = scan_pos;
		if (start) begin
			for (i = 0; i < MAX_PATTERN_BYTES; i++) win[i] = '0;
			here = '0;
			hit_count = '0;
			win_fill = 0;
		end
		for (i = MAX_PATTERN_BYTES - 1; i > 0; i--) win[i] = win[i - 1];
		win[0] = b;
		if (win_fill < MAX_PATTERN_BYTES) win_fill++;
		len = (sig_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(sig_len);
		sig = {sig_high, sig_low};
		hit = (len != 0) && (win_fill >= len);
		for (i = 0; i < len; i++) begin
			if (care_mask[i] && win[len - 1 - i] != sig[8*i +: 8]) hit = 1'b0;
		end
		if (hit && (hit_cap == '0 || hit_count < hit_cap)) begin
			back = len - 1;
			expected_hits = {expected_hits, base_addr + here - back};
			if (hit_count != '1) hit_count++;
		end
		scan_pos = here + 1;
	endtask

	always @(posedge clk) begin
		in_took = arst_n && in_valid && !in_stall;
		if (arst_n) begin
			progress = in_took;
			if (out_valid && !out_stall) begin
				progress = 1'b1;
				if (expected_hits.size() == 0) begin
					report_mismatch("match address with none expected", match_address, '0);
				end else begin
					want_addr = expected_hits.pop_front();
					if (match_address !== want_addr) begin
						report_mismatch("match_address", match_address, want_addr);
					end
					hits_checked++;
				end
			end
			if (in_took) scan_byte(data_byte, scan_start);
			if (cfg_valid && cfg_ready) begin
				progress = 1'b1;
				case (cfg_index)
					REG_PAT_LOW:   sig_low = cfg_data;
					REG_PAT_HIGH:  sig_high = cfg_data;
					REG_MASK:      care_mask = cfg_data[15:0];
					REG_LENGTH:    sig_len = cfg_data[4:0];
					REG_BASE:      base_addr = cfg_data[ADDR_W-1:0];
					REG_HIT_LIMIT: hit_cap = cfg_data[HIT_W-1:0];
					default: ;
				endcase
			end
			quiet_cycles = progress ? 0 : quiet_cycles + 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (byte_queue.size() != 0 && (no_gaps || $urandom_range(99) >= 30)) begin
				next_byte = byte_queue.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_byte.value;
				scan_start <= next_byte.first;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (want_long_hold && !long_hold_done) begin
			long_hold_done = 1'b1;
			hold_left = LONG_HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_gaps && ($urandom_range(99) < 30);
		end
	end

	initial begin
		wait (arst_n);
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Watchdog: no item moved for %0d cycles.", QUIET_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	task automatic push_byte(input logic [7:0] b, input logic first);
		region_byte_t entry;
		entry.value = b;
		entry.first = first;
		byte_queue = {byte_queue, entry};
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (byte_queue.size() != 0 || in_valid || expected_hits.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		logic [63:0] junk;
		logic [15:0] mask;
		logic [4:0]  len;
		logic [31:0] base;
		logic [15:0] cap;
		int          r;
		junk = {$urandom, $urandom};
		if ($urandom_range(3) != 0) junk = '0;
		r = $urandom_range(99);
		if (r < 40) mask = 16'($urandom);
		else if (r < 55) mask = '1;
		else if (r < 65) mask = '0;
		else mask = 16'($urandom) & 16'($urandom);
		r = $urandom_range(99);
		if (r < 8) len = 5'd0;
		else if (r < 16) len = 5'($urandom_range(17, 31));
		else if (r < 24) len = 5'd16;
		else if (r < 40) len = 5'($urandom_range(9, 15));
		else len = 5'($urandom_range(1, 8));
		r = $urandom_range(99);
		if (r < 20) base = '0;
		else if (r < 40) base = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
		else base = $urandom;
		r = $urandom_range(99);
		if (r < 60) cap = '0;
		else if (r < 85) cap = 16'($urandom_range(1, 4));
		else if (r < 95) cap = '1;
		else cap = 16'($urandom);
		write_reg(REG_PAT_LOW, {$urandom, $urandom});
		write_reg(REG_PAT_HIGH, {$urandom, $urandom});
		write_reg(REG_MASK, (junk & ~64'hFFFF) | 64'(mask));
		write_reg(REG_LENGTH, (junk & ~64'h1F) | 64'(len));
		write_reg(REG_BASE, (junk & ~64'hFFFF_FFFF) | 64'(base));
		write_reg(REG_HIT_LIMIT, (junk & ~64'hFFFF) | 64'(cap));
		settings_used++;
	endtask

	// Mostly planted signatures with random wildcard bytes, some with one byte
	// corrupted, and short runs of noise in between.
	task automatic queue_region(input int count, input bit fresh);
		logic [7:0]   chunk[$];
		logic [127:0] sig;
		int           made;
		int           k;
		int           len;
		int           pick;
		int           flip_at;
		made = 0;
		sig = {sig_high, sig_low};
		len = (sig_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(sig_len);
		while (made < count) begin
			chunk.delete();
			pick = $urandom_range(99);
			if (len != 0 && pick < 65) begin
				flip_at = (pick >= 55) ? int'($urandom_range(len - 1)) : -1;
				for (k = 0; k < len; k++) begin
					chunk = {chunk, (care_mask[k] ? sig[8*k +: 8] : 8'($urandom))};
					if (k == flip_at) chunk[k] = chunk[k] ^ 8'($urandom_range(1, 255));
				end
			end else begin
				repeat ($urandom_range(1, 6)) chunk = {chunk, 8'($urandom)};
			end
			foreach (chunk[i]) begin
				push_byte(chunk[i], (made == 0) ? fresh : ($urandom_range(99) < 2));
				made++;
			end
		end
	endtask

	initial begin
		int  i;
		int  n;
		bit  long_phase_done;
		bit  gap_free_done;
		long_phase_done = 1'b0;
		gap_free_done = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: one wildcard byte, so every byte hits, with no scan start.
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hA5, 1'b0);
		wait_drained();

		// Four-byte signature with a wildcard third byte, a base that wraps,
		// and a hit limit of two.
		write_reg(REG_PAT_LOW, 64'h0000_0000_EFBE_ADDE);
		write_reg(REG_PAT_HIGH, '1);
		write_reg(REG_MASK, 64'h000B);
		write_reg(REG_LENGTH, 64'd4);
		write_reg(REG_BASE, 64'hFFFF_FFFE);
		write_reg(REG_HIT_LIMIT, 64'd2);
		settings_used++;
		for (i = 0; i < 3; i++) begin
			push_byte(8'hDE, i == 0);
			push_byte(8'hAD, 1'b0);
			push_byte(8'($urandom), 1'b0);
			push_byte(8'hEF, 1'b0);
		end
		wait_drained();

		// Raising the limit in the middle of a scan lets one more hit through.
		write_reg(REG_HIT_LIMIT, 64'd3);
		settings_used++;
		push_byte(8'hDE, 1'b0);
		push_byte(8'hAD, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hEF, 1'b0);
		wait_drained();

		// An empty signature reports nothing; unmapped indexes change nothing.
		write_reg(REG_LENGTH, 64'd0);
		write_reg(REG_UNMAPPED_A, '1);
		write_reg(REG_UNMAPPED_B, '1);
		settings_used++;
		push_byte(8'hEF, 1'b1);
		push_byte(8'hDE, 1'b0);
		wait_drained();

		while (bytes_sent < TOTAL_BYTES) begin
			if (!long_phase_done && bytes_sent >= 300) begin
				long_phase_done = 1'b1;
				write_reg(REG_LENGTH, 64'd1);
				write_reg(REG_MASK, 64'd0);
				write_reg(REG_HIT_LIMIT, 64'd0);
				settings_used++;
				want_long_hold = 1'b1;
				queue_region(150, 1'b1);
			end else if (!gap_free_done && bytes_sent >= 600) begin
				gap_free_done = 1'b1;
				random_config();
				write_reg(REG_LENGTH, 64'd2);
				no_gaps = 1'b1;
				queue_region(150, 1'b1);
				wait_drained();
				no_gaps = 1'b0;
			end else begin
				random_config();
				n = $urandom_range(40, 120);
				if (settings_used == 7) begin
					queue_region(n / 2, 1'b1);
					wait_drained();
					queue_region(n / 2, 1'b0);
				end else begin
					queue_region(n, $urandom_range(9) < 7);
				end
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_hits.size() != 0) begin
			report_mismatch("predicted match addresses never produced",
				ADDR_W'(expected_hits.size()), '0);
		end
		$display("Scanned %0d region bytes under %0d register settings with gaps on both sides,",
			bytes_sent, settings_used);
		$display("one long output hold-off and one gap-free stretch; %0d match addresses compared.",
			hits_checked);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
